>>> hw/rtl/rlse_pkg.sv
// Shared types, constants and defaults for the RGB LED strip pulse encoder.
package rlse_pkg;

  localparam int MAX_LEDS_DEF      = 64;
  localparam int GROUP_SIZE_DEF    = 4;
  localparam int DURATION_BITS_DEF = 15;

  localparam int PULSES_PER_LED = 24;
  localparam int TICK_W         = 15;
  localparam int LEN_W          = 7;
  localparam int CFG_IDX_W      = 3;

  localparam logic [1:0] OP_SET_PIXEL = 2'd0;
  localparam logic [1:0] OP_SET_GROUP = 2'd1;
  localparam logic [1:0] OP_FILL      = 2'd2;
  localparam logic [1:0] OP_SHOW      = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_STRIP_LENGTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH_TICKS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW_TICKS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH_TICKS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW_TICKS   = 3'd4;

  localparam logic [LEN_W-1:0]  STRIP_LENGTH_RST    = 7'd64;
  localparam logic [TICK_W-1:0] ZERO_HIGH_TICKS_RST = 15'd16;
  localparam logic [TICK_W-1:0] ZERO_LOW_TICKS_RST  = 15'd34;
  localparam logic [TICK_W-1:0] ONE_HIGH_TICKS_RST  = 15'd32;
  localparam logic [TICK_W-1:0] ONE_LOW_TICKS_RST   = 15'd18;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  typedef struct packed {
    logic [1:0] opcode;
    logic [5:0] target_index;
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
  } cmd_t;

  typedef struct packed {
    logic              status_code;
    logic              is_pulse;
    logic              bit_value;
    logic [TICK_W-1:0] high_ticks;
    logic [TICK_W-1:0] low_ticks;
    logic              frame_end;
    logic              last_of_run;
  } result_t;

endpackage

>>> hw/rtl/rlse_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rlse_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/rgb_led_strip_pulse_encoder_top.sv
// Top level of the RGB LED strip pulse encoder: pixel memory, command sequencer, pulse output.
// Set pixel and set group write the LEDs they name, fill writes every LED in use;
// each gives its status result in the cycle after its last write.
// A show command makes one memory read, one load, then 24 pulse results, one a cycle.
// An invalid command gives its status result in the next cycle and leaves the block idle.
// After reset all MAX_LEDS entries of the pixel memory are cleared with busy high; config is taken.
// Results appear on result for one cycle with result_valid high and cannot be held off.
module rgb_led_strip_pulse_encoder_top
  import rlse_pkg::*;
#(
  parameter int MAX_LEDS      = MAX_LEDS_DEF,
  parameter int GROUP_SIZE    = GROUP_SIZE_DEF,
  parameter int DURATION_BITS = DURATION_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  cmd_t                 cmd,
  output result_t              result,
  output logic                 result_valid,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TICK_W-1:0]    cfg_data
);

  localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int CW = $clog2(64 * GROUP_SIZE + MAX_LEDS + 128);
  localparam int BW = $clog2(PULSES_PER_LED);
  localparam logic [TICK_W-1:0] DUR_MASK =
    TICK_W'((32'(1) << DURATION_BITS) - 32'(1));

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_WRITE = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_PULSE = 3'd4;

  logic [2:0]        state;
  logic [AW-1:0]     addr;
  logic [CW-1:0]     remaining;
  logic [AW-1:0]     show_pos;
  logic              last_led;
  logic [BW-1:0]     bit_cnt;
  logic [23:0]       color;
  logic [23:0]       grb;
  logic [LEN_W-1:0]  strip_length;
  logic [TICK_W-1:0] zero_high_ticks;
  logic [TICK_W-1:0] zero_low_ticks;
  logic [TICK_W-1:0] one_high_ticks;
  logic [TICK_W-1:0] one_low_ticks;

  logic [CW-1:0]     len;
  logic [CW-1:0]     first;
  logic [CW-1:0]     pos_ext;
  logic [AW-1:0]     pos_sel;
  logic              accept;
  logic              ram_we;
  logic [23:0]       ram_wdata;
  logic [23:0]       ram_rdata;
  logic              pulse_bit;

  function automatic result_t status_result(input logic st);
    result_t r;
    r             = '0;
    r.status_code = st;
    r.last_of_run = 1'b1;
    return r;
  endfunction

  assign busy      = rst || (state != S_IDLE);
  assign cfg_ready = !rst;
  assign accept    = start && !busy;
  assign pulse_bit = grb[23];

  always_comb begin
    len     = (CW'(strip_length) > CW'(MAX_LEDS)) ? CW'(MAX_LEDS) : CW'(strip_length);
    first   = CW'(cmd.target_index) * CW'(GROUP_SIZE);
    pos_ext = (CW'(show_pos) >= len) ? '0 : CW'(show_pos);
    pos_sel = AW'(pos_ext);
  end

  assign ram_we    = (state == S_CLEAR) || (state == S_WRITE);
  assign ram_wdata = (state == S_CLEAR) ? 24'd0 : color;

  rlse_ram #(
    .WIDTH(24),
    .DEPTH(MAX_LEDS),
    .AW   (AW)
  ) u_pixel_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(addr),
    .wdata(ram_wdata),
    .raddr(pos_sel),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLEAR;
      addr            <= '0;
      remaining       <= '0;
      show_pos        <= '0;
      last_led        <= 1'b0;
      bit_cnt         <= '0;
      result_valid    <= 1'b0;
      strip_length    <= STRIP_LENGTH_RST;
      zero_high_ticks <= ZERO_HIGH_TICKS_RST;
      zero_low_ticks  <= ZERO_LOW_TICKS_RST;
      one_high_ticks  <= ONE_HIGH_TICKS_RST;
      one_low_ticks   <= ONE_LOW_TICKS_RST;
    end else begin
      result_valid <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_STRIP_LENGTH:    strip_length    <= cfg_data[LEN_W-1:0];
          CFG_ZERO_HIGH_TICKS: zero_high_ticks <= cfg_data;
          CFG_ZERO_LOW_TICKS:  zero_low_ticks  <= cfg_data;
          CFG_ONE_HIGH_TICKS:  one_high_ticks  <= cfg_data;
          CFG_ONE_LOW_TICKS:   one_low_ticks   <= cfg_data;
          default: ;
        endcase
      end

      case (state)
        S_CLEAR: begin
          addr <= addr + AW'(1);
          if (addr == AW'(MAX_LEDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            color <= {cmd.red_level, cmd.green_level, cmd.blue_level};
            case (cmd.opcode)
              OP_SET_PIXEL: begin
                if (CW'(cmd.target_index) >= len) begin
                  result       <= status_result(STATUS_INVALID);
                  result_valid <= 1'b1;
                end else begin
                  addr      <= AW'(cmd.target_index);
                  remaining <= CW'(1);
                  state     <= S_WRITE;
                end
              end
              OP_SET_GROUP: begin
                if (first + CW'(GROUP_SIZE) > len) begin
                  result       <= status_result(STATUS_INVALID);
                  result_valid <= 1'b1;
                end else begin
                  addr      <= AW'(first);
                  remaining <= CW'(GROUP_SIZE);
                  state     <= S_WRITE;
                end
              end
              OP_FILL: begin
                if (len == '0) begin
                  result       <= status_result(STATUS_INVALID);
                  result_valid <= 1'b1;
                end else begin
                  addr      <= '0;
                  remaining <= len;
                  state     <= S_WRITE;
                end
              end
              OP_SHOW: begin
                if (len == '0) begin
                  result       <= status_result(STATUS_INVALID);
                  result_valid <= 1'b1;
                end else begin
                  show_pos <= pos_sel;
                  last_led <= (pos_ext + CW'(1) >= len);
                  state    <= S_READ;
                end
              end
              default: ;
            endcase
          end
        end
        S_WRITE: begin
          addr      <= addr + AW'(1);
          remaining <= remaining - CW'(1);
          if (remaining == CW'(1)) begin
            result       <= status_result(STATUS_OK);
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        S_READ: begin
          grb     <= {ram_rdata[15:8], ram_rdata[23:16], ram_rdata[7:0]};
          bit_cnt <= '0;
          state   <= S_PULSE;
        end
        S_PULSE: begin
          result.status_code <= STATUS_OK;
          result.is_pulse    <= 1'b1;
          result.bit_value   <= pulse_bit;
          result.high_ticks  <= (pulse_bit ? one_high_ticks : zero_high_ticks) & DUR_MASK;
          result.low_ticks   <= (pulse_bit ? one_low_ticks : zero_low_ticks) & DUR_MASK;
          result.frame_end   <= (bit_cnt == BW'(PULSES_PER_LED - 1)) && last_led;
          result.last_of_run <= (bit_cnt == BW'(PULSES_PER_LED - 1));
          result_valid       <= 1'b1;
          grb                <= {grb[22:0], 1'b0};
          bit_cnt            <= bit_cnt + BW'(1);
          if (bit_cnt == BW'(PULSES_PER_LED - 1)) begin
            show_pos <= last_led ? '0 : show_pos + AW'(1);
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_pulse_status_ok: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.is_pulse |-> result.status_code == STATUS_OK)
    else $error("pulse result carries an error status");

  a_frame_end_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.frame_end |-> result.last_of_run && result.is_pulse)
    else $error("frame end outside the final pulse of a transaction");

  a_status_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.is_pulse |->
      result.last_of_run && result.high_ticks == '0 && !result.frame_end)
    else $error("status result with pulse fields set");

  a_final_pulse: assert property (@(posedge clk) disable iff (rst)
    state == S_PULSE && bit_cnt == BW'(PULSES_PER_LED - 1) |=>
      result_valid && result.last_of_run && !busy)
    else $error("show did not close after its final pulse");

  a_no_write_when_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !ram_we)
    else $error("pixel memory written while idle");

endmodule
